>>> src/blt_pkg.sv
// ----------------------------------------------------------------------------
// blt_pkg
// Shared types and constants for the binary-lifting tree distance core.
// ----------------------------------------------------------------------------
package blt_pkg;

    // Fixed field widths of the item ports
    localparam int ID_W    = 12;
    localparam int DEPTH_W = 12;

    // Operation codes carried by the op field
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD0,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_Q_DX,
        ST_Q_DY,
        ST_Q_SWAP,
        ST_L_TEST,
        ST_L_ANC,
        ST_L_DEP,
        ST_C_START,
        ST_C_RX,
        ST_C_RY,
        ST_C_CMP,
        ST_C_LCA,
        ST_C_LDEP,
        ST_Q_FIN
    } state_t;

endpackage

>>> src/blt_ram.sv
// ----------------------------------------------------------------------------
// blt_ram
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data, read data holds when idle.
// ----------------------------------------------------------------------------
module blt_ram #(
    parameter int WIDTH  = 12,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [(1 << ADDR_W)];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/binary_lifting_tree_distance_core.sv
// ----------------------------------------------------------------------------
// binary_lifting_tree_distance_core
// Binary-lifting ancestor table with add and distance query items.
// ----------------------------------------------------------------------------
// Items are taken one at a time; in_ready is high only while the sequencer
// is idle. An add (op 0) writes the node's depth and its 2^k ancestors and
// is paced by the chain of dependent ancestor-table reads (one read and one
// write-back per level); an add of node 0 is dropped. A query (op 1) lifts
// the deeper node in the equal-depth phase, one lifting step per set bit of
// the depth gap; when the lifted node already equals the other one the climb
// phase is skipped. The climb phase reads both nodes' ancestors each level
// through the single ancestor-table read port, and every lift rereads the
// depth store. The result sits in an output register, so the next item is
// taken while a finished distance waits; a later query holds in its last
// cycle until that register is free. Node ids are reduced modulo NODES,
// which must be a power of two. Node 0 is the root sentinel: reads of entry
// 0 are forced to zero, so no clearing pass is needed after reset. Both RAMs
// hold undefined contents until written; querying a node never added is not
// supported.
module binary_lifting_tree_distance_core #(
    parameter int NODES  = 4096,
    parameter int LEVELS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         op,
    input  logic [blt_pkg::ID_W-1:0]     node,
    input  logic [blt_pkg::ID_W-1:0]     other,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [blt_pkg::DEPTH_W-1:0]  distance
);

    localparam int IW = $clog2(NODES);
    localparam int LW = $clog2(LEVELS);
    localparam int AW = IW + LW;
    localparam int DW = blt_pkg::DEPTH_W;
    localparam int GW = DW + 5;

    blt_pkg::state_t state_reg, state_next;

    logic [IW-1:0] x_reg, x_next;
    logic [IW-1:0] y_reg, y_next;
    logic [IW-1:0] ax_reg, ax_next;
    logic [LW-1:0] k_reg, k_next;
    logic [DW-1:0] dx_reg, dx_next;
    logic [DW-1:0] dy_reg, dy_next;
    logic [DW-1:0] sum_reg, sum_next;
    logic          az_reg, az_next;
    logic          dz_reg, dz_next;
    logic [DW-1:0] distance_reg, distance_next;
    logic          out_valid_reg, out_valid_next;

    // RAM ports
    logic          anc_we, anc_re;
    logic [IW-1:0] anc_wnode, anc_rnode;
    logic [LW-1:0] anc_wlvl, anc_rlvl;
    logic [IW-1:0] anc_wdata, anc_rdata;
    logic          dep_we, dep_re;
    logic [IW-1:0] dep_waddr, dep_raddr;
    logic [DW-1:0] dep_wdata, dep_rdata;

    logic          accept;
    logic          out_free;
    logic          lift_go;
    logic [IW-1:0] aval;
    logic [DW-1:0] dval;
    logic [GW-1:0] gap;
    logic [GW-1:0] thresh;
    logic [IW-1:0] node_idx;
    logic [IW-1:0] other_idx;

    // Sentinel node 0 always reads as zero
    assign aval = az_reg ? '0 : anc_rdata;
    assign dval = dz_reg ? '0 : dep_rdata;

    assign node_idx  = IW'(node);
    assign other_idx = IW'(other);

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Equal-depth phase: lift x while the depth gap reaches 2^k
    assign gap     = {5'b0, dx_reg} - {5'b0, dy_reg};
    assign thresh  = GW'(1) << k_reg;
    assign lift_go = !gap[GW-1] && (gap >= thresh);

    // Memories
    blt_ram #(
        .WIDTH  (IW),
        .ADDR_W (AW)
    ) u_anc_ram (
        .clk   (clk),
        .we    (anc_we),
        .waddr ({anc_wnode, anc_wlvl}),
        .wdata (anc_wdata),
        .re    (anc_re),
        .raddr ({anc_rnode, anc_rlvl}),
        .rdata (anc_rdata)
    );

    blt_ram #(
        .WIDTH  (DW),
        .ADDR_W (IW)
    ) u_dep_ram (
        .clk   (clk),
        .we    (dep_we),
        .waddr (dep_waddr),
        .wdata (dep_wdata),
        .re    (dep_re),
        .raddr (dep_raddr),
        .rdata (dep_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            blt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == blt_pkg::OP_QUERY)
                    begin
                        state_next = blt_pkg::ST_Q_DX;
                    end
                    else if (node_idx != '0)
                    begin
                        state_next = blt_pkg::ST_ADD0;
                    end
                end
            end
            blt_pkg::ST_ADD0:   state_next = blt_pkg::ST_ADD_RD;
            blt_pkg::ST_ADD_RD: state_next = blt_pkg::ST_ADD_WR;
            blt_pkg::ST_ADD_WR:
            begin
                if (k_reg == LW'(LEVELS - 1))
                begin
                    state_next = blt_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = blt_pkg::ST_ADD_RD;
                end
            end
            blt_pkg::ST_Q_DX:   state_next = blt_pkg::ST_Q_DY;
            blt_pkg::ST_Q_DY:   state_next = blt_pkg::ST_Q_SWAP;
            blt_pkg::ST_Q_SWAP: state_next = blt_pkg::ST_L_TEST;
            blt_pkg::ST_L_TEST:
            begin
                if (lift_go)
                begin
                    state_next = blt_pkg::ST_L_ANC;
                end
                else if (k_reg == '0)
                begin
                    state_next = blt_pkg::ST_C_START;
                end
            end
            blt_pkg::ST_L_ANC:  state_next = blt_pkg::ST_L_DEP;
            blt_pkg::ST_L_DEP:
            begin
                if (k_reg == '0)
                begin
                    state_next = blt_pkg::ST_C_START;
                end
                else
                begin
                    state_next = blt_pkg::ST_L_TEST;
                end
            end
            blt_pkg::ST_C_START:
            begin
                if (x_reg == y_reg)
                begin
                    state_next = blt_pkg::ST_Q_FIN;
                end
                else
                begin
                    state_next = blt_pkg::ST_C_RX;
                end
            end
            blt_pkg::ST_C_RX:   state_next = blt_pkg::ST_C_RY;
            blt_pkg::ST_C_RY:   state_next = blt_pkg::ST_C_CMP;
            blt_pkg::ST_C_CMP:
            begin
                if (k_reg == '0)
                begin
                    state_next = blt_pkg::ST_C_LCA;
                end
                else
                begin
                    state_next = blt_pkg::ST_C_RX;
                end
            end
            blt_pkg::ST_C_LCA:  state_next = blt_pkg::ST_C_LDEP;
            blt_pkg::ST_C_LDEP: state_next = blt_pkg::ST_Q_FIN;
            blt_pkg::ST_Q_FIN:
            begin
                if (out_free)
                begin
                    state_next = blt_pkg::ST_IDLE;
                end
            end
            default:            state_next = blt_pkg::ST_IDLE;
        endcase
    end

    // Memory controls and in_ready per state
    always_comb
    begin
        in_ready  = 1'b0;
        anc_we    = 1'b0;
        anc_wnode = x_reg;
        anc_wlvl  = k_reg;
        anc_wdata = aval;
        anc_re    = 1'b0;
        anc_rnode = x_reg;
        anc_rlvl  = k_reg;
        dep_we    = 1'b0;
        dep_waddr = x_reg;
        dep_wdata = dval + DW'(1);
        dep_re    = 1'b0;
        dep_raddr = x_reg;
        case (state_reg)
            blt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            blt_pkg::ST_ADD0:
            begin
                // level 0 ancestor is the parent; fetch parent depth
                anc_we    = 1'b1;
                anc_wlvl  = '0;
                anc_wdata = y_reg;
                dep_re    = 1'b1;
                dep_raddr = y_reg;
            end
            blt_pkg::ST_ADD_RD:
            begin
                anc_re    = 1'b1;
                anc_rnode = y_reg;
                anc_rlvl  = k_reg - LW'(1);
                dep_we    = (k_reg == LW'(1));
            end
            blt_pkg::ST_ADD_WR:
            begin
                anc_we = 1'b1;
            end
            blt_pkg::ST_Q_DX:
            begin
                dep_re = 1'b1;
            end
            blt_pkg::ST_Q_DY:
            begin
                dep_re    = 1'b1;
                dep_raddr = y_reg;
            end
            blt_pkg::ST_L_TEST:
            begin
                anc_re = lift_go;
            end
            blt_pkg::ST_L_ANC:
            begin
                dep_re    = 1'b1;
                dep_raddr = aval;
            end
            blt_pkg::ST_C_START:
            begin
                dep_re = (x_reg == y_reg);
            end
            blt_pkg::ST_C_RX:
            begin
                anc_re = 1'b1;
            end
            blt_pkg::ST_C_RY:
            begin
                anc_re    = 1'b1;
                anc_rnode = y_reg;
            end
            blt_pkg::ST_C_LCA:
            begin
                anc_re   = 1'b1;
                anc_rlvl = '0;
            end
            blt_pkg::ST_C_LDEP:
            begin
                dep_re    = 1'b1;
                dep_raddr = aval;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        x_next         = x_reg;
        y_next         = y_reg;
        ax_next        = ax_reg;
        k_next         = k_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sum_next       = sum_reg;
        distance_next  = distance_reg;
        out_valid_next = out_valid_reg && !out_ready;
        az_next        = anc_re ? (anc_rnode == '0) : az_reg;
        dz_next        = dep_re ? (dep_raddr == '0) : dz_reg;
        case (state_reg)
            blt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    x_next = node_idx;
                    y_next = other_idx;
                end
            end
            blt_pkg::ST_ADD0:
            begin
                k_next = LW'(1);
            end
            blt_pkg::ST_ADD_WR:
            begin
                // ancestor just written becomes the next lookup row
                y_next = aval;
                k_next = k_reg + LW'(1);
            end
            blt_pkg::ST_Q_DY:
            begin
                dx_next = dval;
            end
            blt_pkg::ST_Q_SWAP:
            begin
                sum_next = dx_reg + dval;
                k_next   = LW'(LEVELS - 1);
                if (dx_reg < dval)
                begin
                    x_next  = y_reg;
                    y_next  = x_reg;
                    dx_next = dval;
                    dy_next = dx_reg;
                end
                else
                begin
                    dy_next = dval;
                end
            end
            blt_pkg::ST_L_TEST:
            begin
                if (!lift_go && k_reg != '0)
                begin
                    k_next = k_reg - LW'(1);
                end
            end
            blt_pkg::ST_L_ANC:
            begin
                x_next = aval;
            end
            blt_pkg::ST_L_DEP:
            begin
                dx_next = dval;
                if (k_reg != '0)
                begin
                    k_next = k_reg - LW'(1);
                end
            end
            blt_pkg::ST_C_START:
            begin
                k_next = LW'(LEVELS - 1);
            end
            blt_pkg::ST_C_RY:
            begin
                ax_next = aval;
            end
            blt_pkg::ST_C_CMP:
            begin
                if (ax_reg != aval)
                begin
                    x_next = ax_reg;
                    y_next = aval;
                end
                if (k_reg != '0)
                begin
                    k_next = k_reg - LW'(1);
                end
            end
            blt_pkg::ST_Q_FIN:
            begin
                // d(x) + d(y) - 2*d(lca), modulo 4096
                if (out_free)
                begin
                    distance_next  = sum_reg - {dval[DW-2:0], 1'b0};
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= blt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        ax_reg       <= ax_next;
        k_reg        <= k_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        sum_reg      <= sum_next;
        az_reg       <= az_next;
        dz_reg       <= dz_next;
        distance_reg <= distance_next;
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;

endmodule
